>>> src/bld_pkg.sv
// Shared types and constants for the battery level detector.
// No dependencies; imported by the top level, the multiplier and the testbench.
package bld_pkg;

  // Command codes of one request.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_LOAD  = 2'd3;

  // Register byte addresses of the request channel.
  localparam logic [4:0] REG_CTL0  = 5'd0;
  localparam logic [4:0] REG_CTL1  = 5'd1;
  localparam logic [4:0] REG_CTL2  = 5'd2;
  localparam logic [4:0] REG_SOLAR = 5'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ERROR    = 3'd0;
  localparam logic [2:0] CFG_INIT     = 3'd1;
  localparam logic [2:0] CFG_TEST     = 3'd2;
  localparam logic [2:0] CFG_CPS      = 3'd3;
  localparam logic [2:0] CFG_SOLAR_TH = 3'd4;

  // Register field masks and bit positions.
  localparam logic [7:0] SEL_MASK   = 8'h1F;
  localparam logic [7:0] IC_MASK    = 8'h37;
  localparam logic [7:0] SLOW_MASK  = 8'h0F;
  localparam int         CTL1_START = 0;
  localparam int         CTL1_MODE  = 2;
  localparam int         IC_END_EN  = 4;
  localparam int         IC_LOW_EN  = 5;
  localparam logic [2:0] IV_REPEAT  = 3'h7;
  localparam logic [2:0] IV_NONE    = 3'h0;

  // Fixed field widths.
  localparam int FRAC_BITS = 16;
  localparam int WDATA_BITS = 13;

  // Status of the shared multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

>>> src/battery_level_detector.sv
// Battery level detector top level: request decode, test sequencer, APB registers.
// Depends on bld_pkg, bld_ram (threshold table) and bld_mul (shared multiplier).
//
// Each request is a tick, a register read, a register write or a threshold table
// load, and produces exactly one result. Register reads, writes, loads and ticks
// that make no level decision go from acceptance through the execute and finish
// states to the result register. A tick that must judge the battery level runs
// the single shift-add multiplier up to three times (threshold times error, then
// the two sides of the in-band timing compare) at one bit per cycle, plus the
// low-band, high-band and final compare steps. The block takes one request at a
// time; a new request is taken while the previous result still waits on out_ready.
// The threshold table powers up undefined: load every entry that will be selected.
module battery_level_detector #(
  parameter int THRESHOLD_ENTRIES = 32,
  parameter int VOLT_BITS         = 13,
  parameter int TIMER_BITS        = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic [4:0]                        in_address,
  input  logic [bld_pkg::WDATA_BITS-1:0]    in_write_data,
  input  logic [VOLT_BITS-1:0]              in_battery_mv,
  input  logic [VOLT_BITS-1:0]              in_solar_mv,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_read_data,
  output logic                              out_low_interrupt,
  output logic                              out_end_interrupt,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [4:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import bld_pkg::*;

  localparam int VW = VOLT_BITS;
  localparam int DW = VW + FRAC_BITS;   // threshold times error
  localparam int AW = DW + 1;           // in-band distance term
  localparam int PW = AW + FRAC_BITS;   // multiplier product
  localparam int TW = TIMER_BITS;
  localparam int IW = $clog2(THRESHOLD_ENTRIES);
  localparam logic [TW-1:0] TMASK = {TW{1'b1}};

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_LO   = 7'b0001000,
    ST_HI   = 7'b0010000,
    ST_RES  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_D = 3'b001,
    PH_L = 3'b010,
    PH_R = 3'b100
  } phase_t;

  // Sequencer and request capture.
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [1:0]            cmd_r;
  logic [4:0]            addr_r;
  logic [WDATA_BITS-1:0] wd_r;
  logic [VW-1:0]         bat_r, sol_r;

  // Block state.
  logic [4:0]    sel_r, sel_nxt;
  logic [5:0]    ic_r, ic_nxt;
  logic          mode_r, mode_nxt, en_r, en_nxt, flag_r, flag_nxt;
  logic          run_r, run_nxt, amode_r, amode_nxt, arep_r, arep_nxt;
  logic [VW-1:0] athr_r, athr_nxt;
  logic          rdone_r, rdone_nxt;
  logic [TW-1:0] timer_r, timer_nxt, delay_r, delay_nxt;
  logic [3:0]    slow_r, slow_nxt;

  // Configuration registers.
  logic [15:0] err_r, init_r, test_r;
  logic [23:0] cps_r;
  logic [12:0] sthr_r;

  // Datapath holding registers.
  logic [DW-1:0] draw_r, draw_nxt;
  logic [AW-1:0] x_r, x_nxt;
  logic          xneg_r, xneg_nxt, hip_r, hip_nxt;
  logic [PW-1:0] lhs_r, lhs_nxt;

  // Pending result and output register.
  logic [7:0] rd_r, rd_nxt;
  logic       low_r, low_nxt, end_r, end_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rd_r, out_rd_nxt;
  logic       out_low_r, out_low_nxt, out_end_r, out_end_nxt;

  // Multiplier hookup.
  logic                  mul_go;
  logic [AW-1:0]         mul_a;
  logic [FRAC_BITS-1:0]  mul_b;
  mul_sts_t              mul_sts;
  logic [PW-1:0]         mul_prod;

  // Threshold table.
  logic          ram_we;
  logic [VW-1:0] ram_rdata, sel_thr;

  // Working values.
  logic [TW-1:0]   timer_inc;
  logic [2:0]      iv;
  logic [31:0]     delay_raw;
  logic [TW-1:0]   delay_sat;
  logic            start_req, start_mode, start_rep;
  logic [7:0]      wbyte;
  logic [15:0]     n_ticks, s_ticks;
  logic [DW-1:0]   dd, v_sh, t_sh;
  logic [DW:0]     t_hi;
  logic signed [VW:0]   dlt;
  logic signed [DW:0]   dlt_sh;
  logic            hip_now;
  logic signed [AW:0]   xs;
  logic            cfg_wr;

  bld_ram #(.WIDTH(VW), .DEPTH(THRESHOLD_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r[IW-1:0]),
    .wdata (VW'(wd_r)),
    .raddr (sel_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  bld_mul #(.AW(AW), .BW(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  assign in_ready = (state_r == ST_IDLE);

  // A selection past the table end reads as threshold zero.
  assign sel_thr = ({1'b0, sel_r} < 6'(THRESHOLD_ENTRIES)) ? ram_rdata : '0;

  assign timer_inc = timer_r + 1'b1;
  assign iv        = ic_r[2:0];
  assign delay_raw = 32'(cps_r) >> iv;
  assign delay_sat = (delay_raw > 32'(TMASK)) ? TMASK : TW'(delay_raw);
  assign wbyte     = wd_r[7:0];

  // Tick counts since the decision window opened and its length.
  assign n_ticks = timer_r[15:0] - init_r;
  assign s_ticks = test_r - init_r;

  // Band edges: threshold scaled by 65536, plus or minus threshold times error.
  assign dd     = (draw_r == '0) ? DW'(1) : draw_r;
  assign v_sh   = {bat_r, {FRAC_BITS{1'b0}}};
  assign t_sh   = {athr_r, {FRAC_BITS{1'b0}}};
  assign t_hi   = {1'b0, t_sh} + {1'b0, draw_r};
  assign dlt    = $signed({1'b0, bat_r}) - $signed({1'b0, athr_r});
  assign dlt_sh = {dlt, {FRAC_BITS{1'b0}}};
  assign hip_now = amode_r || (dlt > 0);
  assign xs = hip_now ? ($signed({2'b00, dd}) - $signed({dlt_sh[DW], dlt_sh}))
                      : ($signed({2'b00, dd}) + $signed({dlt_sh[DW], dlt_sh}));

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    sel_nxt       = sel_r;
    ic_nxt        = ic_r;
    mode_nxt      = mode_r;
    en_nxt        = en_r;
    flag_nxt      = flag_r;
    run_nxt       = run_r;
    amode_nxt     = amode_r;
    arep_nxt      = arep_r;
    athr_nxt      = athr_r;
    rdone_nxt     = rdone_r;
    timer_nxt     = timer_r;
    delay_nxt     = delay_r;
    slow_nxt      = slow_r;
    draw_nxt      = draw_r;
    x_nxt         = x_r;
    xneg_nxt      = xneg_r;
    hip_nxt       = hip_r;
    lhs_nxt       = lhs_r;
    rd_nxt        = rd_r;
    low_nxt       = low_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_low_nxt   = out_low_r;
    out_end_nxt   = out_end_r;
    mul_go        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;
    start_req     = 1'b0;
    start_mode    = mode_r;
    start_rep     = 1'b0;

    // Drop the shown result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rd_nxt    = '0;
          low_nxt   = 1'b0;
          end_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_FIN;
        case (cmd_r)
          CMD_TICK: begin
            if (run_r) begin
              timer_nxt = timer_inc;
              if (timer_inc >= TW'(test_r)) begin
                // End of test: stop, then repeat, idle or wait out the interval.
                run_nxt = 1'b0;
                if (iv == IV_NONE) begin
                  end_nxt = ic_r[IC_END_EN];
                  en_nxt  = 1'b0;
                end else if (arep_r) begin
                  start_req = 1'b1;
                  start_rep = (iv == IV_REPEAT);
                end else begin
                  end_nxt   = ic_r[IC_END_EN];
                  timer_nxt = '0;
                  delay_nxt = delay_sat;
                end
              end else if (!(timer_inc < TW'(init_r)) && !rdone_r) begin
                // Decision window open: form threshold times error first.
                mul_go    = 1'b1;
                mul_a     = AW'(athr_r);
                mul_b     = err_r;
                phase_nxt = PH_D;
                state_nxt = ST_MUL;
              end
            end else if (en_r) begin
              timer_nxt = timer_inc;
              if (timer_inc >= delay_r) begin
                start_req = 1'b1;
                start_rep = (iv == IV_REPEAT);
              end
            end
          end
          CMD_READ: begin
            case (addr_r)
              REG_CTL0:  rd_nxt = {3'b000, sel_r};
              REG_CTL1:  rd_nxt = {5'b00000, mode_r, flag_r, en_r};
              REG_CTL2:  rd_nxt = {2'b00, ic_r};
              REG_SOLAR: rd_nxt = {3'b000, (16'(sol_r) >= 16'(sthr_r)), slow_r};
              default:   rd_nxt = '0;
            endcase
          end
          CMD_WRITE: begin
            case (addr_r)
              REG_CTL0:  sel_nxt = 5'(wbyte & SEL_MASK);
              REG_CTL1: begin
                mode_nxt   = wbyte[CTL1_MODE];
                start_mode = wbyte[CTL1_MODE];
                if (wbyte[CTL1_START]) begin
                  en_nxt    = 1'b1;
                  start_req = !run_r;
                end else begin
                  en_nxt  = 1'b0;
                  run_nxt = 1'b0;
                end
              end
              REG_CTL2:  ic_nxt   = 6'(wbyte & IC_MASK);
              REG_SOLAR: slow_nxt = 4'(wbyte & SLOW_MASK);
              default: ;
            endcase
          end
          CMD_LOAD: begin
            ram_we = ({1'b0, addr_r} < 6'(THRESHOLD_ENTRIES));
          end
          default: ;
        endcase
      end

      ST_MUL: begin
        if (mul_sts.done) begin
          case (phase_r)
            PH_D: begin
              draw_nxt  = DW'(mul_prod);
              state_nxt = ST_LO;
            end
            PH_L: begin
              lhs_nxt = mul_prod;
              if (xneg_r) begin
                // Negative right side: the timing compare holds already.
                state_nxt = ST_FIN;
                if (hip_r) begin
                  flag_nxt  = 1'b1;
                  rdone_nxt = 1'b1;
                end else begin
                  flag_nxt  = 1'b0;
                  rdone_nxt = 1'b1;
                  low_nxt   = ic_r[IC_LOW_EN];
                end
              end else begin
                mul_go    = 1'b1;
                mul_a     = x_r;
                mul_b     = s_ticks;
                phase_nxt = PH_R;
              end
            end
            PH_R: state_nxt = ST_RES;
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_LO: begin
        if (v_sh < (t_sh - draw_r)) begin
          flag_nxt  = 1'b0;
          rdone_nxt = 1'b1;
          low_nxt   = ic_r[IC_LOW_EN];
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_HI;
        end
      end

      ST_HI: begin
        if ({1'b0, v_sh} > t_hi) begin
          flag_nxt  = 1'b1;
          rdone_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          // In band: place the decision tick by the relative distance.
          hip_nxt   = hip_now;
          x_nxt     = xs[AW-1:0];
          xneg_nxt  = xs[AW];
          mul_go    = 1'b1;
          mul_a     = AW'(dd);
          mul_b     = n_ticks;
          phase_nxt = PH_L;
          state_nxt = ST_MUL;
        end
      end

      ST_RES: begin
        state_nxt = ST_FIN;
        if ({lhs_r, 1'b0} >= {1'b0, mul_prod}) begin
          rdone_nxt = 1'b1;
          if (hip_r) begin
            flag_nxt = 1'b1;
          end else begin
            flag_nxt = 1'b0;
            low_nxt  = ic_r[IC_LOW_EN];
          end
        end
      end

      ST_FIN: begin
        // Hold until the output register is free, then advance the result.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_low_nxt   = low_r;
          out_end_nxt   = end_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Start a test: latch the mode, repeat flag and selected threshold.
    if (start_req) begin
      run_nxt   = 1'b1;
      amode_nxt = start_mode;
      arep_nxt  = start_rep;
      athr_nxt  = sel_thr;
      rdone_nxt = 1'b0;
      timer_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_D;
      sel_r       <= '0;
      ic_r        <= '0;
      mode_r      <= 1'b0;
      en_r        <= 1'b0;
      flag_r      <= 1'b1;
      run_r       <= 1'b0;
      amode_r     <= 1'b0;
      arep_r      <= 1'b0;
      athr_r      <= '0;
      rdone_r     <= 1'b0;
      timer_r     <= '0;
      delay_r     <= '0;
      slow_r      <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 16'd3277;
      init_r      <= 16'd16;
      test_r      <= 16'd256;
      cps_r       <= 24'd1048576;
      sthr_r      <= 13'd1000;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      sel_r       <= sel_nxt;
      ic_r        <= ic_nxt;
      mode_r      <= mode_nxt;
      en_r        <= en_nxt;
      flag_r      <= flag_nxt;
      run_r       <= run_nxt;
      amode_r     <= amode_nxt;
      arep_r      <= arep_nxt;
      athr_r      <= athr_nxt;
      rdone_r     <= rdone_nxt;
      timer_r     <= timer_nxt;
      delay_r     <= delay_nxt;
      slow_r      <= slow_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          CFG_ERROR:    err_r  <= cfg_pwdata[15:0];
          CFG_INIT:     init_r <= cfg_pwdata[15:0];
          CFG_TEST:     test_r <= cfg_pwdata[15:0];
          CFG_CPS:      cps_r  <= cfg_pwdata[23:0];
          CFG_SOLAR_TH: sthr_r <= cfg_pwdata[12:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
      wd_r   <= in_write_data;
      bat_r  <= in_battery_mv;
      sol_r  <= in_solar_mv;
    end
    draw_r    <= draw_nxt;
    x_r       <= x_nxt;
    xneg_r    <= xneg_nxt;
    hip_r     <= hip_nxt;
    lhs_r     <= lhs_nxt;
    rd_r      <= rd_nxt;
    low_r     <= low_nxt;
    end_r     <= end_nxt;
    out_rd_r  <= out_rd_nxt;
    out_low_r <= out_low_nxt;
    out_end_r <= out_end_nxt;
  end

  always_comb begin
    case (cfg_paddr[4:2])
      CFG_ERROR:    cfg_prdata = 32'(err_r);
      CFG_INIT:     cfg_prdata = 32'(init_r);
      CFG_TEST:     cfg_prdata = 32'(test_r);
      CFG_CPS:      cfg_prdata = 32'(cps_r);
      CFG_SOLAR_TH: cfg_prdata = 32'(sthr_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg_pready        = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_low_interrupt = out_low_r;
  assign out_end_interrupt = out_end_r;

`ifndef NO_ASSERTIONS
  // The multiplier never runs while a new request may be taken.
  a_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mul_sts.busy)
    else $error("multiplier busy while idle");

  // Multiplier results arrive only while the sequencer waits for them.
  a_done_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == ST_MUL))
    else $error("multiplier result outside wait state");

  // The final compare always follows a multiplier pass.
  a_res_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES) |-> ($past(state_r) == ST_MUL))
    else $error("compare step without multiplier pass");

  // Interrupts come from ticks only, which never carry read data.
  a_int_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_low_interrupt || out_end_interrupt)) |-> (out_read_data == 8'd0))
    else $error("interrupt with read data");
`endif

endmodule

>>> src/bld_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module bld_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> src/bld_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on bld_pkg for the status struct.
module bld_mul #(
  parameter int AW = 30,
  parameter int BW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output bld_pkg::mul_sts_t sts,
  output logic [AW+BW-1:0]  prod
);
  import bld_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW);
  localparam logic [CW-1:0] LAST = CW'(BW - 1);

  logic [PW-1:0] a_r, acc_r;
  logic [BW-1:0] b_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= PW'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule

>>> dv/battery_level_detector_checker.sv
// Checker for the battery level detector: watches the request, result and APB ports.
// Predicts each result from its own copy of the registers and the test state.
// Depends on bld_pkg.
module battery_level_detector_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_address,
  input  logic [12:0] in_write_data,
  input  logic [12:0] in_battery_mv,
  input  logic [12:0] in_solar_mv,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic        out_low_interrupt,
  input  logic        out_end_interrupt,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  input  logic        end_check,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bld_pkg::*;

  typedef struct packed {
    logic [7:0] rd;
    logic       low;
    logic       fin;
  } level_result_t;

  level_result_t expected_results[$];

  logic [15:0] err_frac, init_len, test_len;
  logic [23:0] sec_cycles;
  logic [12:0] solar_th;

  logic [4:0]  sel;
  logic [5:0]  ictl;
  logic        mode, en, flag, running, run_mode, run_rep, decided;
  logic [12:0] run_thr;
  logic [23:0] timer, wait_len;
  logic [3:0]  solar_bits;
  logic [12:0] thr_table [32];
  logic        low_irq, end_irq;
  logic        end_done;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void begin_run(input logic m, input logic r);
    if (running) return;
    running = 1;
    run_mode = m;
    run_rep = r;
    run_thr = thr_table[sel];
    decided = 0;
    timer = '0;
  endfunction

  function automatic void end_run();
    logic [2:0] iv;
    iv = ictl[2:0];
    if (!running) return;
    running = 0;
    if (iv == IV_NONE) begin
      if (ictl[IC_END_EN]) end_irq = 1;
      en = 0;
      return;
    end
    if (run_rep) begin
      begin_run(mode, iv == IV_REPEAT);
      return;
    end
    if (ictl[IC_END_EN]) end_irq = 1;
    timer = '0;
    wait_len = sec_cycles >> iv;
  endfunction

  function automatic void flag_low();
    flag = 0;
    decided = 1;
    if (ictl[IC_LOW_EN]) low_irq = 1;
  endfunction

  function automatic void flag_high();
    flag = 1;
    decided = 1;
  endfunction

  function automatic void judge_tick(input logic [12:0] bat);
    longint volt, thr, ef, dv, dprod, nt, st, lhs;
    timer = timer + 24'd1;
    if (timer >= test_len) begin
      end_run();
      return;
    end
    if (timer < init_len || decided) return;
    volt = bat;
    thr = run_thr;
    ef = err_frac;
    if (volt * 65536 < thr * (65536 - ef)) begin
      flag_low();
      return;
    end
    if (volt * 65536 > thr * (65536 + ef)) begin
      flag_high();
      return;
    end
    dv = volt - thr;
    dprod = thr * ef;
    if (dprod == 0) dprod = 1;
    nt = longint'(timer) - longint'(init_len);
    st = longint'(test_len) - longint'(init_len);
    lhs = 2 * dprod * nt;
    if (run_mode || dv > 0) begin
      if (lhs >= (dprod - 65536 * dv) * st) flag_high();
    end else if (lhs >= (dprod + 65536 * dv) * st) begin
      flag_low();
    end
  endfunction

  // Advance the detector by one request and return what it should answer.
  function automatic level_result_t compute_level_result(
      input logic [1:0] cmd, input logic [4:0] addr, input logic [12:0] wd,
      input logic [12:0] bat, input logic [12:0] sol);
    level_result_t r;
    logic [7:0] b;
    r = '0;
    low_irq = 0;
    end_irq = 0;
    b = wd[7:0];
    case (cmd)
      CMD_TICK: begin
        if (running) judge_tick(bat);
        else if (en) begin
          timer = timer + 24'd1;
          if (timer >= wait_len) begin_run(mode, ictl[2:0] == IV_REPEAT);
        end
      end
      CMD_READ: begin
        case (addr)
          REG_CTL0:  r.rd = {3'b0, sel};
          REG_CTL1:  r.rd = {5'b0, mode, flag, en};
          REG_CTL2:  r.rd = {2'b0, ictl};
          REG_SOLAR: r.rd = {3'b0, sol >= solar_th, solar_bits};
          default:   r.rd = '0;
        endcase
      end
      CMD_WRITE: begin
        case (addr)
          REG_CTL0: sel = b[4:0];
          REG_CTL1: begin
            mode = b[CTL1_MODE];
            if (b[CTL1_START]) begin
              en = 1;
              begin_run(mode, 0);
            end else begin
              en = 0;
              running = 0;
            end
          end
          REG_CTL2:  ictl = b[5:0] & IC_MASK[5:0];
          REG_SOLAR: solar_bits = b[3:0];
          default: ;
        endcase
      end
      default: thr_table[addr] = wd;
    endcase
    r.low = low_irq;
    r.fin = end_irq;
    return r;
  endfunction

  always @(posedge clk) begin
    level_result_t got, want;
    if (!rst_n) begin
      err_frac = 16'd3277;
      init_len = 16'd16;
      test_len = 16'd256;
      sec_cycles = 24'd1048576;
      solar_th = 13'd1000;
      sel = '0; ictl = '0; mode = 0; en = 0; flag = 1; running = 0;
      run_mode = 0; run_rep = 0; run_thr = '0; decided = 0;
      timer = '0; wait_len = '0; solar_bits = '0;
      foreach (thr_table[i]) thr_table[i] = '0;
      expected_results.delete();
      end_done = 0;
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          CFG_ERROR:    err_frac = cfg_pwdata[15:0];
          CFG_INIT:     init_len = cfg_pwdata[15:0];
          CFG_TEST:     test_len = cfg_pwdata[15:0];
          CFG_CPS:      sec_cycles = cfg_pwdata[23:0];
          CFG_SOLAR_TH: solar_th = cfg_pwdata[12:0];
          default: ;
        endcase
      end
      // Compare the oldest expectation first; a result never belongs to a same-edge request.
      if (out_valid && out_ready) begin
        got = {out_read_data, out_low_interrupt, out_end_interrupt};
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (got.rd !== want.rd)
            report_mismatch($sformatf("read_data %0h, want %0h", got.rd, want.rd));
          if (got.low !== want.low)
            report_mismatch($sformatf("low_interrupt %b, want %b", got.low, want.low));
          if (got.fin !== want.fin)
            report_mismatch($sformatf("end_interrupt %b, want %b", got.fin, want.fin));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(compute_level_result(in_command, in_address,
            in_write_data, in_battery_mv, in_solar_mv));
      if (end_check && !end_done) begin
        end_done = 1;
        if (expected_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
    end
  end
endmodule

>>> dv/battery_level_detector_test.sv
// Top of the battery level detector testbench: clock, reset, stimulus and verdict.
// Depends on bld_pkg, battery_level_detector and battery_level_detector_checker.
module battery_level_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bld_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 64;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_command;
  logic [4:0]  in_address;
  logic [12:0] in_write_data, in_battery_mv, in_solar_mv;
  logic        out_valid, out_ready;
  logic [7:0]  out_read_data;
  logic        out_low_interrupt, out_end_interrupt;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        end_check;
  int          fail_count;

  int          requests_sent, results_taken, cycles;
  logic        calm;              // stretch with no idling on either side
  logic [12:0] thr_shadow [32];   // thresholds as loaded, to aim voltages near them
  logic [4:0]  sel_shadow;

  battery_level_detector dut (.*);

  battery_level_detector_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("battery_level_detector_test failed");
      $finish;
    end
  end

  // Result side: draw a stall per result, then hold ready until the result is taken.
  initial begin
    int stall;
    out_ready = 0;
    results_taken = 0;
    wait (rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      repeat (stall) @(negedge clk) out_ready = 0;
      @(negedge clk) out_ready = 1;
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      results_taken++;
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [4:0] addr,
                              input logic [12:0] wd, input logic [12:0] bat,
                              input logic [12:0] sol);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk) in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    in_command = cmd;
    in_address = addr;
    in_write_data = wd;
    in_battery_mv = bat;
    in_solar_mv = sol;
    // Hold the request until the block takes it.
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    requests_sent++;
    if (cmd == CMD_LOAD) thr_shadow[addr] = wd;
    if (cmd == CMD_WRITE && addr == REG_CTL0) sel_shadow = wd[4:0];
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1;
    cfg_pwrite = 1;
    cfg_penable = 0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk) cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
  endtask

  // Drain every outstanding result, then let a judging tick finish.
  task automatic wait_idle();
    @(negedge clk) in_valid = 0;
    wait (results_taken == requests_sent);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [15:0] err, input logic [15:0] init_t,
                                input logic [15:0] test_t, input logic [23:0] cps,
                                input logic [12:0] sol_th);
    wait_idle();
    cfg_write(CFG_ERROR, 32'(err));
    cfg_write(CFG_INIT, 32'(init_t));
    cfg_write(CFG_TEST, 32'(test_t));
    cfg_write(CFG_CPS, 32'(cps));
    cfg_write(CFG_SOLAR_TH, 32'(sol_th));
  endtask

  // Battery voltage mostly inside or just around the band of the selected threshold.
  function automatic logic [12:0] near_battery();
    int thr, span, v;
    thr = thr_shadow[sel_shadow];
    span = (thr >> 3) + 4;
    v = thr + $urandom_range(0, 2 * span) - span;
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v[12:0];
  endfunction

  task automatic random_request();
    int pick;
    logic [12:0] wd, bat, sol;
    pick = $urandom_range(0, 99);
    wd = $urandom;
    sol = $urandom;
    bat = ($urandom_range(0, 9) < 7) ? near_battery() : 13'($urandom);
    if (pick < 55)
      send_request(CMD_TICK, 5'($urandom), wd, bat, sol);
    else if (pick < 63) begin
      // Mostly start, sometimes stop.
      wd[CTL1_START] = $urandom_range(0, 3) != 0;
      send_request(CMD_WRITE, REG_CTL1, wd, bat, sol);
    end else if (pick < 70)
      send_request(CMD_WRITE, REG_CTL2, wd, bat, sol);
    else if (pick < 75)
      send_request(CMD_WRITE, REG_CTL0, wd, bat, sol);
    else if (pick < 80)
      send_request(CMD_WRITE, ($urandom_range(0, 1) ? REG_SOLAR : 5'($urandom)), wd, bat, sol);
    else if (pick < 88)
      send_request(CMD_READ, ($urandom_range(0, 3) ? 5'($urandom_range(0, 3)) : 5'($urandom)),
                   wd, bat, sol);
    else if (pick < 93)
      send_request(CMD_LOAD, 5'($urandom), wd, bat, sol);
    else
      send_request(2'($urandom), 5'($urandom), wd, bat, sol);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) calm = $urandom_range(0, 3) == 0;
      random_request();
    end
    calm = 0;
  endtask

  initial begin
    int init_t;
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_TICK;
    in_address = '0;
    in_write_data = '0;
    in_battery_mv = '0;
    in_solar_mv = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    end_check = 0;
    calm = 0;
    requests_sent = 0;
    cycles = 0;
    sel_shadow = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // Fill the whole table first so no test ever selects an unwritten entry.
    for (int i = 0; i < 32; i++)
      send_request(CMD_LOAD, 5'(i), (i == 0) ? 13'd0 : (i == 31) ? 13'h1FFF :
                   13'($urandom_range(500, 6000)), '0, '0);

    // Directed: every register, unknown addresses, field extremes.
    set_thresholds(16'd3277, 16'd1, 16'd6, 24'd4, 13'd1000);
    send_request(CMD_READ, REG_CTL0, '0, '0, '0);
    send_request(CMD_READ, REG_CTL1, '0, '0, '0);
    send_request(CMD_READ, REG_CTL2, '0, '0, '0);
    send_request(CMD_READ, REG_SOLAR, '0, '0, 13'h1FFF);
    send_request(CMD_READ, 5'd31, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    send_request(CMD_WRITE, 5'd7, 13'h1FFF, '0, '0);
    send_request(CMD_WRITE, REG_SOLAR, 13'h1FFF, '0, '0);
    send_request(CMD_READ, REG_SOLAR, '0, '0, '0);
    send_request(CMD_WRITE, REG_CTL2, 13'h1FFF, '0, '0);
    send_request(CMD_WRITE, REG_CTL0, 13'h1FFF, '0, '0);
    send_request(CMD_WRITE, REG_CTL1, 13'h0005, '0, '0);
    send_request(CMD_WRITE, REG_CTL1, 13'h0001, '0, '0);
    repeat (8) send_request(CMD_TICK, '0, '0, 13'h1FFF, '0);
    send_request(CMD_WRITE, REG_CTL0, 13'h0000, '0, '0);
    send_request(CMD_WRITE, REG_CTL1, 13'h0000, '0, '0);
    send_request(CMD_WRITE, REG_CTL1, 13'h0001, '0, '0);
    repeat (4) send_request(CMD_TICK, '0, '0, 13'h0000, '0);
    send_request(CMD_READ, REG_CTL1, '0, '0, '0);

    set_thresholds(16'd3277, 16'd2, 16'd12, 24'd64, 13'd1000);
    random_phase(250);
    set_thresholds(16'd0, 16'd0, 16'd1, 24'd1, 13'd0);
    random_phase(250);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 13'h1FFF);
    random_phase(150);
    set_thresholds(16'd20000, 16'd5, 16'd40, 24'd300, 13'd4000);
    random_phase(300);
    init_t = $urandom_range(0, 10);
    set_thresholds(16'($urandom), 16'(init_t), 16'(init_t + $urandom_range(1, 50)),
                   24'($urandom_range(1, 500)), 13'($urandom));
    random_phase(300);

    wait_idle();
    @(negedge clk) end_check = 1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("battery_level_detector_test passed");
    else
      $display("battery_level_detector_test failed");
    $finish;
  end
endmodule

>>> battery_level_detector.f
src/bld_pkg.sv
src/bld_ram.sv
src/bld_mul.sv
src/battery_level_detector.sv
dv/battery_level_detector_checker.sv
dv/battery_level_detector_test.sv
